>>> src/sortq_pkg.sv
// Shared types and constants of the sorted priority queue.
package sortq_pkg;

   localparam int PRIO_W   = 8;
   localparam int ID_W     = 16;
   localparam int ENTRY_W  = PRIO_W + ID_W;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // request codes
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic              req_type;
      logic [PRIO_W-1:0] priority_req;
      logic [ID_W-1:0]   process_id;
   } req_payload_type;

   typedef struct packed {
      logic [PRIO_W-1:0]   popped_priority;
      logic [ID_W-1:0]     popped_id;
      logic [PRIO_W-1:0]   head_priority;
      logic [ID_W-1:0]     head_id;
      logic                empty_res;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

endpackage

>>> src/sortq_chan_if.sv
// Valid/ready channel interface carrying one payload per transaction.
interface sortq_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> src/sortq_ram.sv
// Generic one-write, one-read RAM with registered read data.
module sortq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/sorted_priority_queue.sv
// Top level of the sorted priority queue: sequencer, entry RAM and result register.
//
// Channels: req_if (sink) takes one transaction per request; req_type selects push
//   (insert priority_req/process_id) or pop (remove the head entry). rsp_if (source)
//   returns one transaction per request: the popped entry (zero on push or failure),
//   the new head (zero when empty), the empty flag, the count and a status (ok, push
//   dropped on full, pop on empty). Entries sit sorted in a QUEUE_DEPTH-entry RAM,
//   smallest priority at slot 0; equal priorities leave in arrival order.
// Sequencing: one request at a time; req_if.ready is high only while the
//   sequencer idles. A push moves one entry a cycle from the tail toward the head
//   through the RAM's single write port until the new entry's slot is found, then
//   writes the new entry. A pop of c >= 2 entries moves c - 1 entries up one slot.
//   Errors, a push to an empty queue and a pop of the last entry go straight to
//   the result state. The sequencer idles again as its result is registered.
// Reset: synchronous, active high; the queue empties and no result is pending.
//   RAM contents are not cleared; only slots below the count are used.
// Stalls: a finished result waits in the output register while rsp_if.ready is low;
//   the next request is still accepted and worked on, its result held in the
//   sequencer until the output register frees.
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   sortq_chan_if.sink   req_if,
   sortq_chan_if.source rsp_if
);
   import sortq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_PUSH_CMP = 5'b00010,
      S_PUSH_INS = 5'b00100,
      S_POP_MV   = 5'b01000,
      S_DONE     = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   entry_type       head_ff, head_in;
   entry_type       popped_ff, popped_in;
   entry_type       new_ff, new_in;
   status_type      status_ff, status_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_entry;
   logic [CNT_W-1:0] count_m1;

   // Entry store: slot 0 holds the head.
   sortq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_sortq_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_entry)
   );

   assign count_m1     = count_ff - CNT_W'(1);
   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      head_in        = head_ff;
      popped_in      = popped_ff;
      new_in         = new_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_entry       = new_ff;
      rd_addr        = idx_ff;

      // Drop the held result once the receiver takes it.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // Prefetch the tail for a push, slot 1 for a pop.
            if (req_if.payload.req_type == REQ_PUSH) begin
               rd_addr = count_m1[IDX_W-1:0];
            end else begin
               rd_addr = IDX_W'(1);
            end
            if (req_if.valid) begin
               new_in.prio = req_if.payload.priority_req;
               new_in.id   = req_if.payload.process_id;
               popped_in   = '0;
               status_in   = ST_OK;
               if (req_if.payload.req_type == REQ_PUSH) begin
                  if (count_ff == FULL_CNT) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else if (count_ff == '0) begin
                     // Empty queue: the new entry becomes the head directly.
                     wr_en          = 1'b1;
                     wr_addr        = '0;
                     wr_entry.prio  = req_if.payload.priority_req;
                     wr_entry.id    = req_if.payload.process_id;
                     head_in        = wr_entry;
                     count_in       = CNT_W'(1);
                     state_in       = S_DONE;
                  end else begin
                     idx_in   = count_ff[IDX_W-1:0];
                     state_in = S_PUSH_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     popped_in = head_ff;
                     if (count_ff == CNT_W'(1)) begin
                        count_in = '0;
                        state_in = S_DONE;
                     end else begin
                        idx_in   = IDX_W'(1);
                        state_in = S_POP_MV;
                     end
                  end
               end
            end
         end

         S_PUSH_CMP: begin
            // rd_entry holds slot idx-1; move it down while it ranks behind.
            if (rd_entry.prio > new_ff.prio) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff;
               wr_entry = rd_entry;
               idx_in   = idx_ff - IDX_W'(1);
               rd_addr  = idx_ff - IDX_W'(2);
               if (idx_ff == IDX_W'(1)) begin
                  state_in = S_PUSH_INS;
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff;
               wr_entry = new_ff;
               count_in = count_ff + CNT_W'(1);
               state_in = S_DONE;
            end
         end

         S_PUSH_INS: begin
            // New entry goes in at the head.
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_entry = new_ff;
            head_in  = new_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = S_DONE;
         end

         S_POP_MV: begin
            // rd_entry holds slot idx; advance it one slot toward the head.
            wr_en    = 1'b1;
            wr_addr  = idx_ff - IDX_W'(1);
            wr_entry = rd_entry;
            if (idx_ff == IDX_W'(1)) begin
               head_in = rd_entry;
            end
            if ((CNT_W'(idx_ff) + CNT_W'(1)) < count_ff) begin
               idx_in  = idx_ff + IDX_W'(1);
               rd_addr = idx_ff + IDX_W'(1);
            end else begin
               count_in = count_m1;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in                   = 1'b1;
               rsp_payload_in.popped_priority = popped_ff.prio;
               rsp_payload_in.popped_id       = popped_ff.id;
               rsp_payload_in.empty_res       = (count_ff == '0);
               rsp_payload_in.head_priority   = (count_ff == '0) ? '0 : head_ff.prio;
               rsp_payload_in.head_id         = (count_ff == '0) ? '0 : head_ff.id;
               rsp_payload_in.count           = COUNT_W'(count_ff);
               rsp_payload_in.status          = status_ff;
               state_in                       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      head_ff        <= head_in;
      popped_ff      <= popped_in;
      new_ff         <= new_in;
      status_ff      <= status_in;
      rsp_payload_ff <= rsp_payload_in;
   end
endmodule

>>> src/sortq_checker.sv
// Port-level checks of the sorted priority queue, bound to the top level.
module sortq_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input sortq_pkg::rsp_payload_type rsp_payload
);
   import sortq_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped or changed while stalled");

   // A taken request keeps the block busy for at least the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while still busy");

   // A dropped push reports a full queue.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_FULL |->
         rsp_payload.count == FULL_COUNT && !rsp_payload.empty_res)
      else $error("full status with wrong count");

   // A failed pop reports an empty queue and nothing removed.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_EMPTY |->
         rsp_payload.empty_res && rsp_payload.count == '0 &&
         rsp_payload.popped_priority == '0 && rsp_payload.popped_id == '0)
      else $error("empty status with wrong fields");

   // No result right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");
endmodule

bind sorted_priority_queue sortq_checker #(
   .QUEUE_DEPTH(QUEUE_DEPTH)
) u_sortq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_payload(rsp_if.payload)
);

>>> tb/sv/tb.sv
// Self-checking testbench of the sorted priority queue: directed table, then random traffic.
module tb;
   import sortq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   // random push/pop traffic after the directed table
   localparam int RANDOM_ITEMS = 1880;
   // no idling on either side during the last stretch of random items
   localparam int CALM_ITEMS   = 150;
   // settling time at the end, sized from QUEUE_DEPTH with margin
   localparam int SETTLE_CYCLES = QUEUE_DEPTH + 12;

   // one row of the directed table; typed rows carry a hand-written expectation
   typedef struct {
      req_payload_type req;
      bit              typed;
      rsp_payload_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;

   sortq_chan_if #(.payload_type(req_payload_type)) req_if ();
   sortq_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   sorted_priority_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // Mirror of the queue contents, head at index 0, and the responses still owed.
   entry_type       held_entries[$];
   rsp_payload_type expected_rsp[$];
   int              fail_count = 0;
   bit              calm = 1'b0;
   int              stall_left = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Apply one request to the mirror and return the response it must produce.
   function automatic rsp_payload_type advance_queue_model(input req_payload_type r);
      rsp_payload_type o;
      entry_type       e;
      int              pos;
      o = '0;
      o.status = ST_OK;
      if (r.req_type == REQ_PUSH) begin
         if (held_entries.size() >= QUEUE_DEPTH) begin
            // drop the entry, leave the queue as it is
            o.status = ST_FULL;
         end else begin
            // walk past every entry of equal or smaller value: ties stay in arrival order
            pos = 0;
            while (pos < held_entries.size() && held_entries[pos].prio <= r.priority_req)
               pos++;
            e.prio = r.priority_req;
            e.id   = r.process_id;
            held_entries.insert(pos, e);
         end
      end else begin
         if (held_entries.size() == 0) begin
            o.status = ST_EMPTY;
         end else begin
            e = held_entries.pop_front();
            o.popped_priority = e.prio;
            o.popped_id       = e.id;
         end
      end
      // head fields read zero on an empty queue
      if (held_entries.size() > 0) begin
         o.head_priority = held_entries[0].prio;
         o.head_id       = held_entries[0].id;
      end
      o.empty_res = (held_entries.size() == 0);
      o.count     = COUNT_W'(held_entries.size());
      return o;
   endfunction

   function automatic stim_row_type plain_row(input logic op, input logic [PRIO_W-1:0] p,
                                              input logic [ID_W-1:0] id);
      stim_row_type row;
      row.req.req_type     = op;
      row.req.priority_req = p;
      row.req.process_id   = id;
      row.typed            = 1'b0;
      row.rsp              = '0;
      return row;
   endfunction

   // Drive one transaction, hold it until accepted, then queue its expected response.
   // Returns at a falling edge with valid still high, so back-to-back items never
   // lower and raise valid in the same time step.
   task automatic send_request(input req_payload_type p, input bit typed,
                               input rsp_payload_type want);
      int              gap;
      rsp_payload_type predicted;
      gap = 0;
      if (!calm && $urandom_range(3) == 0)
         gap = $urandom_range(1, 7);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      do
         @(posedge clock);
      while (!(req_if.valid && req_if.ready));
      // keep the mirror in step even when the expectation is typed in by hand
      predicted = advance_queue_model(p);
      if (typed)
         predicted = want;
      expected_rsp.push_back(predicted);
      @(negedge clock);
   endtask

   task automatic check_response(input rsp_payload_type want, input rsp_payload_type got);
      if (got.popped_priority !== want.popped_priority) begin
         $error("popped_priority: expected %0h, got %0h", want.popped_priority,
                got.popped_priority);
         fail_count++;
      end
      if (got.popped_id !== want.popped_id) begin
         $error("popped_id: expected %0h, got %0h", want.popped_id, got.popped_id);
         fail_count++;
      end
      if (got.head_priority !== want.head_priority) begin
         $error("head_priority: expected %0h, got %0h", want.head_priority,
                got.head_priority);
         fail_count++;
      end
      if (got.head_id !== want.head_id) begin
         $error("head_id: expected %0h, got %0h", want.head_id, got.head_id);
         fail_count++;
      end
      if (got.empty_res !== want.empty_res) begin
         $error("empty_res: expected %0h, got %0h", want.empty_res, got.empty_res);
         fail_count++;
      end
      if (got.count !== want.count) begin
         $error("count: expected %0d, got %0d", want.count, got.count);
         fail_count++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         fail_count++;
      end
   endtask

   // Result side: compare every accepted transaction with the oldest expectation.
   always @(posedge clock) begin : rsp_monitor
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsp.size() == 0) begin
            $error("response with no request outstanding: %0h", rsp_if.payload);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_response(want, rsp_if.payload);
         end
      end
   end

   // Result side back-pressure: random stall bursts, none when calm.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!calm && !reset && $urandom_range(4) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 6);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      stim_row_type    table_rows[$];
      stim_row_type    row;
      req_payload_type r;
      int              n;
      int              k;
      int              phase_len;
      int              push_pct;
      int              prio_mode;

      // start every input at a known value with reset held, then release it
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table. Pop on an empty queue right after reset.
      row = plain_row(REQ_POP, 8'h00, 16'h0000);
      row.typed = 1'b1;
      row.rsp   = rsp_payload_type'{8'h00, 16'h0000, 8'h00, 16'h0000, 1'b1, 5'd0, ST_EMPTY};
      table_rows.push_back(row);
      // largest field values become the head of an empty queue
      row = plain_row(REQ_PUSH, 8'hFF, 16'hFFFF);
      row.typed = 1'b1;
      row.rsp   = rsp_payload_type'{8'h00, 16'h0000, 8'hFF, 16'hFFFF, 1'b0, 5'd1, ST_OK};
      table_rows.push_back(row);
      // smallest values jump to the head; equal priorities keep arrival order
      table_rows.push_back(plain_row(REQ_PUSH, 8'h00, 16'h0000));
      table_rows.push_back(plain_row(REQ_PUSH, 8'h80, 16'h1111));
      table_rows.push_back(plain_row(REQ_PUSH, 8'h80, 16'h2222));
      table_rows.push_back(plain_row(REQ_PUSH, 8'h00, 16'h0001));
      table_rows.push_back(plain_row(REQ_POP, 8'h00, 16'h0000));
      table_rows.push_back(plain_row(REQ_POP, 8'h5A, 16'hA5A5));
      // fill to the brim behind the 0x80 entries
      for (k = 0; k < 13; k++)
         table_rows.push_back(plain_row(REQ_PUSH, 8'h81 + 8'(k * 8), 16'hA5A0 + 16'(k)));
      // push to a full queue: dropped even though it would become the head
      row = plain_row(REQ_PUSH, 8'h00, 16'hBEEF);
      row.typed = 1'b1;
      row.rsp   = rsp_payload_type'{8'h00, 16'h0000, 8'h80, 16'h1111, 1'b0, 5'd16, ST_FULL};
      table_rows.push_back(row);
      // pop from a full queue
      row = plain_row(REQ_POP, 8'h00, 16'h0000);
      row.typed = 1'b1;
      row.rsp   = rsp_payload_type'{8'h80, 16'h1111, 8'h80, 16'h2222, 1'b0, 5'd15, ST_OK};
      table_rows.push_back(row);
      table_rows.push_back(plain_row(REQ_POP, 8'h00, 16'h0000));

      foreach (table_rows[i])
         send_request(table_rows[i].req, table_rows[i].typed, table_rows[i].rsp);

      // Random part: phases of push-heavy and pop-heavy traffic sweep the queue
      // between empty and full; priorities often crowd the ends to force ties.
      n = 0;
      while (n < RANDOM_ITEMS) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(3))
            0: push_pct = 15;
            1: push_pct = 50;
            2: push_pct = 80;
            default: push_pct = 95;
         endcase
         for (k = 0; k < phase_len && n < RANDOM_ITEMS; k++) begin
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            // once, hold the sender until every outstanding response is back
            if (n == RANDOM_ITEMS / 2) begin
               req_if.valid <= 1'b0;
               @(negedge clock);
               while (expected_rsp.size() != 0)
                  @(negedge clock);
            end
            r.req_type   = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
            prio_mode    = $urandom_range(3);
            case (prio_mode)
               0: r.priority_req = 8'($urandom_range(3));
               1: r.priority_req = 8'($urandom_range(252, 255));
               default: r.priority_req = 8'($urandom_range(255));
            endcase
            r.process_id = 16'($urandom_range(16'hFFFF));
            send_request(r, 1'b0, '0);
            n++;
         end
      end
      req_if.valid <= 1'b0;

      // drain outstanding responses, then let the queue settle to catch strays
      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
